[rtl/oahi_pkg.sv]
package oahi_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH) + 1;

  localparam int CMD_W       = 2;
  localparam int KEY_W       = 31;
  localparam int POS_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic PROBE_LINEAR    = 1'b0;
  localparam logic PROBE_QUADRATIC = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] read_key;
    logic             read_valid;
  } out_item_t;

endpackage

[rtl/oahi_ram.sv]
module oahi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/open_addressing_hash_insert.sv]
// Open-addressing hash table, up to 32 slots of 31-bit keys. Issue a command with start while
// busy is low; the result appears for exactly one cycle with out_valid and cannot be held off.
// Insert first folds the key into its home slot (key mod size) with a shift-and-subtract
// remainder, one key bit per cycle; then it probes one slot per cycle, at most size probes,
// and the result follows in the next cycle. The same 6-bit compare-and-subtract unit serves
// the remainder and each probe step. A read keeps busy high for one cycle (key store read)
// and shows its result in the cycle after that; clear and unknown commands answer in the
// cycle after start. Occupancy flags are cleared at once by reset and by clear, so there is
// no startup sweep.
module open_addressing_hash_insert (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  oahi_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output oahi_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [oahi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oahi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import oahi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic [SIZE_W-1:0]      table_size_r;
  logic                   probe_mode_r;
  logic [TABLE_DEPTH-1:0] occ_r;
  logic [KEY_W-1:0]       key_r;
  logic [4:0]             bit_cnt_r;
  logic [SIZE_W-1:0]      idx_r;
  logic [SIZE_W-1:0]      d_r;
  logic [SIZE_W-1:0]      j_r;
  logic                   rd_occ_r;
  logic [POS_W-1:0]       rd_slot_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [SIZE_W-1:0]      n_eff;
  logic [SIZE_W-1:0]      red_in;
  logic [SIZE_W-1:0]      red_nxt;
  logic [SIZE_W-1:0]      d_plus2;
  logic [SIZE_W-1:0]      d_nxt;
  logic [ADDR_W-1:0]      probe_addr;
  logic                   probe_free;
  logic                   accept;
  logic                   ram_we;
  logic                   ram_re;
  logic [KEY_W-1:0]       ram_rdata;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // clamp the configured size into 1..TABLE_DEPTH
  always_comb begin
    if (table_size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (table_size_r > SIZE_W'(TABLE_DEPTH)) begin
      n_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_eff = table_size_r;
    end
  end

  // shared reduce unit: input always below 2*n
  assign red_in  = (state_r == ST_HASH) ? {idx_r[SIZE_W-2:0], key_r[bit_cnt_r]}
                                        : idx_r + d_r;
  assign red_nxt = (red_in >= n_eff) ? red_in - n_eff : red_in;

  // quadratic step: d tracks (2j+1) mod n
  assign d_plus2 = d_r + SIZE_W'(2);
  always_comb begin
    if (n_eff == SIZE_W'(1)) begin
      d_nxt = '0;
    end else if (d_plus2 >= n_eff) begin
      d_nxt = d_plus2 - n_eff;
    end else begin
      d_nxt = d_plus2;
    end
  end

  assign probe_addr = idx_r[ADDR_W-1:0];
  assign probe_free = !occ_r[probe_addr];
  assign ram_we     = (state_r == ST_PROBE) && probe_free;
  assign ram_re     = accept && (in_data.command == CMD_READ);

  oahi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (probe_addr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (in_data.slot[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      table_size_r <= SIZE_W'(TABLE_DEPTH);
      probe_mode_r <= PROBE_LINEAR;
      occ_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        if (cfg_index == REG_TABLE_SIZE) begin
          table_size_r <= cfg_wdata[SIZE_W-1:0];
        end else begin
          probe_mode_r <= cfg_wdata[0];
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            key_r     <= in_data.key;
            rd_slot_r <= in_data.slot;
            rd_occ_r  <= occ_r[in_data.slot[ADDR_W-1:0]];
            unique case (in_data.command)
              CMD_INSERT: begin
                bit_cnt_r <= 5'(KEY_W - 1);
                idx_r     <= '0;
                state_r   <= ST_HASH;
              end
              CMD_READ: begin
                state_r <= ST_READ;
              end
              CMD_CLEAR: begin
                occ_r       <= '0;
                out_valid_r <= 1'b1;
                out_r       <= '0;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_r       <= '0;
              end
            endcase
          end
        end

        ST_HASH: begin
          idx_r     <= red_nxt;
          bit_cnt_r <= bit_cnt_r - 5'd1;
          if (bit_cnt_r == 5'd0) begin
            j_r     <= '0;
            d_r     <= SIZE_W'(1);
            state_r <= ST_PROBE;
          end
        end

        ST_PROBE: begin
          if (probe_free) begin
            occ_r[probe_addr]  <= 1'b1;
            out_valid_r        <= 1'b1;
            out_r.status       <= STATUS_OK;
            out_r.position     <= POS_W'(idx_r);
            out_r.read_key     <= '0;
            out_r.read_valid   <= 1'b0;
            state_r            <= ST_IDLE;
          end else if (j_r == n_eff - SIZE_W'(1)) begin
            out_valid_r        <= 1'b1;
            out_r.status       <= STATUS_FAIL;
            out_r.position     <= '0;
            out_r.read_key     <= '0;
            out_r.read_valid   <= 1'b0;
            state_r            <= ST_IDLE;
          end else begin
            idx_r <= red_nxt;
            j_r   <= j_r + SIZE_W'(1);
            if (probe_mode_r == PROBE_QUADRATIC) begin
              d_r <= d_nxt;
            end
          end
        end

        ST_READ: begin
          out_valid_r      <= 1'b1;
          out_r.status     <= STATUS_OK;
          out_r.position   <= rd_slot_r;
          out_r.read_key   <= rd_occ_r ? ram_rdata : '0;
          out_r.read_valid <= rd_occ_r;
          state_r          <= ST_IDLE;
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/oahi_checker.sv]
module oahi_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  oahi_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  oahi_pkg::out_item_t                 out_data
);
  import oahi_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // reset drops any work and any pending beat
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // clear answers next cycle with an all-zero beat
  a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_CLEAR |=> out_valid && out_data == '0)
    else $error("clear beat missing or nonzero");

  // read holds busy one cycle, then returns the requested slot
  a_read_beat: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_READ |=> busy ##1
      (out_valid && out_data.position == $past(in_data.slot, 2)))
    else $error("read beat late or wrong slot");

  // insert starts with the hash pass, no beat yet
  a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == CMD_INSERT |=> busy && !out_valid)
    else $error("insert did not enter hash pass");

  // failed insert reports slot zero and no read data
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FAIL |->
      out_data.position == '0 && out_data.read_valid == 1'b0 && out_data.read_key == '0)
    else $error("failed insert carries stray fields");

endmodule

bind open_addressing_hash_insert oahi_checker u_oahi_checker (.*);

[bench/tb_open_addressing_hash_insert.sv]
`timescale 1ns / 100ps

module tb_open_addressing_hash_insert;
  import oahi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    bit          is_cfg;
    logic [5:0]  size_word;
    logic [5:0]  mode_word;
    in_item_t    item;
    bit          has_known;
    out_item_t   known_res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the table and its registers
  logic [5:0]             tbl_size = 6'd32;
  logic                   quad_mode = PROBE_LINEAR;
  logic [KEY_W-1:0]       slot_key [TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0]   slot_used = '0;
  bit [TABLE_DEPTH-1:0]   ever_written = '0;

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        idle_pct = 0;

  always #2 clk = ~clk;

  open_addressing_hash_insert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic out_item_t hash_table_apply(in_item_t it);
    out_item_t res;
    int        n;
    int        home;
    int        probe;
    int        j;
    bit        placed;
    res = '0;
    placed = 1'b0;
    case (it.command)
      CMD_INSERT: begin
        if (tbl_size == 6'd0) n = 1;
        else if (tbl_size > TABLE_DEPTH) n = TABLE_DEPTH;
        else n = int'(tbl_size);
        home = int'({1'b0, it.key} % n);
        for (j = 0; j < n && !placed; j++) begin
          probe = (home + ((quad_mode == PROBE_QUADRATIC) ? j * j : j)) % n;
          if (!slot_used[probe]) begin
            slot_used[probe] = 1'b1;
            ever_written[probe] = 1'b1;
            slot_key[probe] = it.key;
            res.position = probe[POS_W-1:0];
            placed = 1'b1;
          end
        end
        if (!placed) res.status = STATUS_FAIL;
      end
      CMD_READ: begin
        res.position = it.slot;
        if (slot_used[it.slot]) begin
          res.read_valid = 1'b1;
          res.read_key = slot_key[it.slot];
        end
      end
      CMD_CLEAR: slot_used = '0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic dir_row_t op_row(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                      logic [POS_W-1:0] s);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.size_word = '0;
    r.mode_word = '0;
    r.item.command = c;
    r.item.key = k;
    r.item.slot = s;
    r.has_known = 1'b0;
    r.known_res = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                         logic [POS_W-1:0] s, logic st,
                                         logic [POS_W-1:0] pos, logic [KEY_W-1:0] rk,
                                         logic rv);
    dir_row_t r;
    r = op_row(c, k, s);
    r.has_known = 1'b1;
    r.known_res.status = st;
    r.known_res.position = pos;
    r.known_res.read_key = rk;
    r.known_res.read_valid = rv;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [5:0] size_word, logic [5:0] mode_word);
    dir_row_t r;
    r = op_row(CMD_INSERT, '0, '0);
    r.is_cfg = 1'b1;
    r.size_word = size_word;
    r.mode_word = mode_word;
    return r;
  endfunction

  // Present one command; start may drop on any cycle while it waits for busy to clear.
  task automatic issue(input in_item_t item, input bit has_known, input out_item_t known_res);
    out_item_t predicted;
    in_data <= item;
    do begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
    end while (!(start && !busy));
    predicted = hash_table_apply(item);
    pending_results.push_back(has_known ? known_res : predicted);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_regs(input logic [5:0] size_word, input logic [5:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TABLE_SIZE;
    cfg_wdata <= size_word;
    @(posedge clk);
    cfg_index <= REG_PROBE_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tbl_size  = size_word;
    quad_mode = mode_word[0];
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("field status: expected %0d, actual %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.position !== want.position) begin
          $error("field position: expected %0d, actual %0d", want.position,
                 out_data.position);
          mismatch_count++;
        end
        if (out_data.read_key !== want.read_key) begin
          $error("field read_key: expected %h, actual %h", want.read_key, out_data.read_key);
          mismatch_count++;
        end
        if (out_data.read_valid !== want.read_valid) begin
          $error("field read_valid: expected %0d, actual %0d", want.read_valid,
                 out_data.read_valid);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t   directed[$];
    in_item_t   item;
    logic [5:0] size_word;
    int         phase;
    int         session;
    int         k;
    int         j;
    int         r;
    int         sel;
    int         first_slot;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(known_row(CMD_INSERT, 31'd0, 5'd0, STATUS_OK, 5'd0, 31'd0, 1'b0));
    directed.push_back(known_row(CMD_INSERT, 31'd31, 5'd31, STATUS_OK, 5'd31, 31'd0, 1'b0));
    directed.push_back(op_row(CMD_INSERT, 31'h7FFF_FFFF, 5'd0));
    directed.push_back(op_row(CMD_INSERT, 31'd32, 5'd0));
    // same key again lands in a second slot
    directed.push_back(op_row(CMD_INSERT, 31'd0, 5'd0));
    directed.push_back(known_row(CMD_READ, 31'd0, 5'd0, STATUS_OK, 5'd0, 31'd0, 1'b1));
    directed.push_back(known_row(CMD_READ, 31'd0, 5'd31, STATUS_OK, 5'd31, 31'd31, 1'b1));
    directed.push_back(op_row(CMD_READ, 31'h7FFF_FFFF, 5'd1));
    directed.push_back(cfg_row(6'd1, {5'd0, PROBE_LINEAR}));
    directed.push_back(known_row(CMD_INSERT, 31'd3, 5'd0, STATUS_FAIL, 5'd0, 31'd0, 1'b0));
    // slots past the new size keep their keys
    directed.push_back(known_row(CMD_READ, 31'd0, 5'd31, STATUS_OK, 5'd31, 31'd31, 1'b1));
    directed.push_back(known_row(CMD_UNUSED, 31'h7FFF_FFFF, 5'd31, STATUS_OK, 5'd0, 31'd0,
                                 1'b0));
    directed.push_back(known_row(CMD_CLEAR, 31'h7FFF_FFFF, 5'd31, STATUS_OK, 5'd0, 31'd0,
                                 1'b0));
    directed.push_back(known_row(CMD_READ, 31'd0, 5'd31, STATUS_OK, 5'd31, 31'd0, 1'b0));
    directed.push_back(known_row(CMD_INSERT, 31'h7FFF_FFFF, 5'd0, STATUS_OK, 5'd0, 31'd0,
                                 1'b0));
    directed.push_back(known_row(CMD_INSERT, 31'd5, 5'd0, STATUS_FAIL, 5'd0, 31'd0, 1'b0));
    // size zero acts as one
    directed.push_back(cfg_row(6'd0, {5'd0, PROBE_LINEAR}));
    directed.push_back(known_row(CMD_INSERT, 31'd9, 5'd0, STATUS_FAIL, 5'd0, 31'd0, 1'b0));
    directed.push_back(known_row(CMD_CLEAR, 31'd0, 5'd0, STATUS_OK, 5'd0, 31'd0, 1'b0));
    // oversize clamps to full depth
    directed.push_back(cfg_row(6'h3F, {5'd0, PROBE_QUADRATIC}));
    directed.push_back(op_row(CMD_INSERT, 31'd0, 5'd0));
    directed.push_back(op_row(CMD_INSERT, 31'd32, 5'd0));
    directed.push_back(op_row(CMD_INSERT, 31'd64, 5'd0));
    directed.push_back(op_row(CMD_INSERT, 31'd96, 5'd0));
    // quadratic steps on four slots only reach 0 and 1, both taken
    directed.push_back(cfg_row(6'd4, {5'd0, PROBE_QUADRATIC}));
    directed.push_back(known_row(CMD_INSERT, 31'd0, 5'd0, STATUS_FAIL, 5'd0, 31'd0, 1'b0));
    directed.push_back(op_row(CMD_READ, 31'd0, 5'd9));
    directed.push_back(op_row(CMD_READ, 31'd0, 5'd2));

    idle_pct = 28;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_regs(directed[i].size_word, directed[i].mode_word);
      end else begin
        issue(directed[i].item, directed[i].has_known, directed[i].known_res);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
      for (session = 0; session < 6; session++) begin
        settle();
        case ($urandom_range(9))
          0: size_word = 6'd1;
          1: size_word = 6'd32;
          2: size_word = 6'd0;
          3: size_word = 6'($urandom_range(63, 33));
          default: size_word = 6'($urandom_range(12, 2));
        endcase
        write_regs(size_word, {5'($urandom_range(31)), 1'($urandom_range(1))});
        if ($urandom_range(1) == 1) begin
          item.command = CMD_CLEAR;
          item.key = 31'($urandom);
          item.slot = 5'($urandom_range(31));
          issue(item, 1'b0, '0);
        end
        for (k = 0; k < 22; k++) begin
          sel = $urandom_range(9);
          if (sel == 0) item.key = 31'h7FFF_FFFF;
          else if (sel == 1) item.key = 31'd0;
          else if (sel < 6) item.key = 31'($urandom_range(95));
          else item.key = 31'($urandom);
          item.slot = 5'($urandom_range(31));
          r = $urandom_range(99);
          if (r < 62 || ever_written == '0) begin
            item.command = CMD_INSERT;
          end else if (r < 86) begin
            // read only slots that have held a key since reset
            item.command = CMD_READ;
            first_slot = $urandom_range(31);
            for (j = 0; j < TABLE_DEPTH; j++) begin
              if (ever_written[(first_slot + j) % TABLE_DEPTH]) begin
                item.slot = 5'((first_slot + j) % TABLE_DEPTH);
                break;
              end
            end
          end else if (r < 93) begin
            item.command = CMD_CLEAR;
          end else begin
            item.command = CMD_UNUSED;
          end
          issue(item, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (70) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/oahi_pkg.sv
rtl/oahi_ram.sv
rtl/open_addressing_hash_insert.sv
rtl/oahi_checker.sv
bench/tb_open_addressing_hash_insert.sv
